>>> hw/rtl/frn_pkg.sv
`default_nettype none
package frn_pkg;

   // Field widths on the streams
   localparam int COMP_W = 16;   // signed Q2.14 vector component
   localparam int ETA_W  = 16;   // unsigned Q4.12 index of refraction
   localparam int REFL_W = 16;   // unsigned Q1.15 reflectance

   // Internal fixed-point widths
   localparam int FRAC_W   = 28;            // Q.28 cosines and sines
   localparam int ROOT_W   = FRAC_W + 1;    // cosine or sine up to 1.0
   localparam int RAD_W    = 2 * ROOT_W;    // square root radicand
   localparam int PROD_W   = ETA_W + ROOT_W;
   localparam int DEN_W    = PROD_W + 1;
   localparam int COEF_SH  = 18;            // Q.18 coefficients
   localparam int COEF_W   = COEF_SH + 1;
   localparam int SQR_W    = 2 * COEF_W;

   localparam logic [RAD_W-1:0]  RAD_ONE  = 58'h100_0000_0000_0000;  // 1.0 in Q.56
   localparam logic [ETA_W-1:0]  ETA_ONE  = 16'd4096;                // 1.0 in Q.12
   localparam logic [REFL_W-1:0] REFL_ONE = 16'd32768;               // 1.0 in Q.15

   // Per-item values carried beside the arithmetic
   typedef struct packed {
      logic [ROOT_W-1:0] cos_i;
      logic [ETA_W-1:0]  eta_i;
      logic [ETA_W-1:0]  eta_t;
   } frn_media_type;

   typedef struct packed {
      frn_media_type media;
      logic          tir;
   } frn_snell_type;

endpackage
`default_nettype wire

>>> hw/rtl/frn_sqrt.sv
`default_nettype none
module frn_sqrt
   import frn_pkg::*;
#(
   parameter int ROOT_BITS = ROOT_W,
   parameter int SIDE_W    = 1
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   adv,
   input  wire logic                   in_valid,
   input  wire logic [2*ROOT_BITS-1:0] in_rad,
   input  wire logic [SIDE_W-1:0]      in_side,
   output logic                        out_valid,
   output logic [ROOT_BITS-1:0]        out_root,
   output logic [SIDE_W-1:0]           out_side
);

   localparam int R_W   = 2 * ROOT_BITS;
   localparam int REM_W = ROOT_BITS + 3;

   logic                 valid_ff [ROOT_BITS];
   logic [R_W-1:0]       rad_ff   [ROOT_BITS];
   logic [REM_W-1:0]     rem_ff   [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff  [ROOT_BITS];
   logic [SIDE_W-1:0]    side_ff  [ROOT_BITS];

   // One root bit per stage, two radicand bits brought down each time
   for (genvar s = 0; s < ROOT_BITS; s++) begin : g_stage
      logic                 valid_at;
      logic [R_W-1:0]       rad_at;
      logic [REM_W-1:0]     rem_at;
      logic [ROOT_BITS-1:0] root_at;
      logic [SIDE_W-1:0]    side_at;
      logic [REM_W-1:0]     rem_sh;
      logic [REM_W-1:0]     trial;
      logic                 ge;

      if (s == 0) begin : g_first
         assign valid_at = in_valid;
         assign rad_at   = in_rad;
         assign rem_at   = '0;
         assign root_at  = '0;
         assign side_at  = in_side;
      end else begin : g_next
         assign valid_at = valid_ff[s-1];
         assign rad_at   = rad_ff[s-1];
         assign rem_at   = rem_ff[s-1];
         assign root_at  = root_ff[s-1];
         assign side_at  = side_ff[s-1];
      end

      assign rem_sh = {rem_at[REM_W-3:0], rad_at[R_W-1 -: 2]};
      assign trial  = {1'b0, root_at, 2'b01};
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv) begin
            valid_ff[s] <= valid_at;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[s]  <= {rad_at[R_W-3:0], 2'b00};
            rem_ff[s]  <= ge ? (rem_sh - trial) : rem_sh;
            root_ff[s] <= {root_at[ROOT_BITS-2:0], ge};
            side_ff[s] <= side_at;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_BITS-1];
   assign out_root  = root_ff[ROOT_BITS-1];
   assign out_side  = side_ff[ROOT_BITS-1];

endmodule
`default_nettype wire

>>> hw/rtl/frn_div.sv
`default_nettype none
module frn_div
   import frn_pkg::*;
#(
   parameter int DIV_W  = ETA_W,
   parameter int QUO_W  = FRAC_W,
   parameter int SIDE_W = 1
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   adv,
   input  wire logic                   in_valid,
   input  wire logic [DIV_W+QUO_W-1:0] in_num,   // must stay below in_den * 2^QUO_W
   input  wire logic [DIV_W-1:0]       in_den,
   input  wire logic [SIDE_W-1:0]      in_side,
   output logic                        out_valid,
   output logic [QUO_W-1:0]            out_quo,
   output logic [SIDE_W-1:0]           out_side
);

   localparam int W = DIV_W + QUO_W;

   logic               valid_ff [QUO_W];
   logic [W-1:0]       rem_ff   [QUO_W];
   logic [DIV_W-1:0]   den_ff   [QUO_W];
   logic [QUO_W-1:0]   quo_ff   [QUO_W];
   logic [SIDE_W-1:0]  side_ff  [QUO_W];

   // Restoring division, one quotient bit per stage from the top
   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      localparam int BIT = QUO_W - 1 - s;
      logic              valid_at;
      logic [W-1:0]      rem_at;
      logic [DIV_W-1:0]  den_at;
      logic [QUO_W-1:0]  quo_at;
      logic [SIDE_W-1:0] side_at;
      logic [W-1:0]      trial;
      logic              ge;
      logic [QUO_W-1:0]  quo_in;

      if (s == 0) begin : g_first
         assign valid_at = in_valid;
         assign rem_at   = in_num;
         assign den_at   = in_den;
         assign quo_at   = '0;
         assign side_at  = in_side;
      end else begin : g_next
         assign valid_at = valid_ff[s-1];
         assign rem_at   = rem_ff[s-1];
         assign den_at   = den_ff[s-1];
         assign quo_at   = quo_ff[s-1];
         assign side_at  = side_ff[s-1];
      end

      assign trial = {{QUO_W{1'b0}}, den_at} << BIT;
      assign ge    = (rem_at >= trial);

      always_comb begin
         quo_in      = quo_at;
         quo_in[BIT] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv) begin
            valid_ff[s] <= valid_at;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s]  <= ge ? (rem_at - trial) : rem_at;
            den_ff[s]  <= den_at;
            quo_ff[s]  <= quo_in;
            side_ff[s] <= side_at;
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule
`default_nettype wire

>>> hw/rtl/fresnel_dielectric_reflectance_core.sv
`default_nettype none
// Channel  Dir  Ports                       Transfer carries
// req      in   req_tvalid/tready/tdata     incident x,y,z, normal x,y,z, refr_index
// rsp      out  rsp_tvalid/tready/tdata/user reflectance, total_internal flag
//
// One item per cycle enters while the pipeline is not held.
// The depth is set by the two 29-stage square root pipelines and the 28- and 19-stage
// dividers, each resolving one bit per stage.
// Synchronous active-high reset clears all stage valid bits; no other state.
// The whole pipeline holds while the output register is full and not taken.
module fresnel_dielectric_reflectance_core
   import frn_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // [15:0] incident_x, [31:16] incident_y, [47:32] incident_z,
   // [63:48] normal_x, [79:64] normal_y, [95:80] normal_z, [111:96] refr_index
   input  wire logic [111:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [15:0]       rsp_tdata,   // [15:0] reflectance
   output logic [0:0]        rsp_tuser    // [0] total_internal
);

   localparam logic signed [33:0] DOT_ONE = 34'sd268435456;
   localparam logic signed [33:0] DOT_NEG = -34'sd268435456;
   localparam int MED_W = $bits(frn_media_type);
   localparam int SNL_W = $bits(frn_snell_type);

   logic adv;

   // Advance when the output register is empty or being taken
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // Stage 1: component products
   logic signed [31:0] px_in, py_in, pz_in;
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic [ETA_W-1:0]   ior1_ff;
   logic               v1_ff;

   assign px_in = $signed(req_tdata[15:0])  * $signed(req_tdata[63:48]);
   assign py_in = $signed(req_tdata[31:16]) * $signed(req_tdata[79:64]);
   assign pz_in = $signed(req_tdata[47:32]) * $signed(req_tdata[95:80]);

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         pz_ff   <= pz_in;
         ior1_ff <= req_tdata[111:96];
      end
   end

   // Stage 2: dot product, clamp, pick media
   logic signed [33:0] dot, dot_cl, dot_mag;
   logic               leaving;
   logic [ETA_W-1:0]   ior_fix;
   frn_media_type      med2_in, med2_ff;
   logic               v2_ff;

   assign dot = {{2{px_ff[31]}}, px_ff} + {{2{py_ff[31]}}, py_ff}
              + {{2{pz_ff[31]}}, pz_ff};

   always_comb begin
      if (dot > DOT_ONE) begin
         dot_cl = DOT_ONE;
      end else if (dot < DOT_NEG) begin
         dot_cl = DOT_NEG;
      end else begin
         dot_cl = dot;
      end
   end

   assign dot_mag = dot_cl[33] ? -dot_cl : dot_cl;
   assign leaving = !dot[33] && (dot != '0);
   assign ior_fix = (ior1_ff == '0) ? 16'd1 : ior1_ff;

   always_comb begin
      med2_in.cos_i = dot_mag[ROOT_W-1:0];
      med2_in.eta_i = leaving ? ior_fix : ETA_ONE;
      med2_in.eta_t = leaving ? ETA_ONE : ior_fix;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         med2_ff <= med2_in;
      end
   end

   // Stage 3: radicand for sin_i
   logic [RAD_W-1:0] cc, rad3_in, rad3_ff;
   frn_media_type    med3_ff;
   logic             v3_ff;

   assign cc      = med2_ff.cos_i * med2_ff.cos_i;
   assign rad3_in = RAD_ONE - cc;

   always_ff @(posedge clock) begin
      if (adv) begin
         rad3_ff <= rad3_in;
         med3_ff <= med2_ff;
      end
   end

   // sin_i
   logic              v4;
   logic [ROOT_W-1:0] sin_i;
   logic [MED_W-1:0]  med4_raw;
   frn_media_type     med4;

   frn_sqrt #(.ROOT_BITS(ROOT_W), .SIDE_W(MED_W)) u_sqrt_sin (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v3_ff),
      .in_rad    (rad3_ff),
      .in_side   (med3_ff),
      .out_valid (v4),
      .out_root  (sin_i),
      .out_side  (med4_raw)
   );

   assign med4 = frn_media_type'(med4_raw);

   // Stage 5: eta_i * sin_i
   logic [PROD_W-1:0] num5_in, num5_ff;
   frn_media_type     med5_ff;
   logic              v5_ff;

   assign num5_in = med4.eta_i * sin_i;

   always_ff @(posedge clock) begin
      if (adv) begin
         num5_ff <= num5_in;
         med5_ff <= med4;
      end
   end

   // Stage 6: total internal reflection test
   frn_snell_type           snl6_in, snl6_ff;
   logic [ETA_W+FRAC_W-1:0] num6_ff;
   logic                    v6_ff;

   always_comb begin
      snl6_in.media = med5_ff;
      snl6_in.tir   = (num5_ff >= {1'b0, med5_ff.eta_t, {FRAC_W{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         snl6_ff <= snl6_in;
         num6_ff <= num5_ff[ETA_W+FRAC_W-1:0];
      end
   end

   // sin_t
   logic              v7d;
   logic [FRAC_W-1:0] sin_t;
   logic [SNL_W-1:0]  snl7_raw;

   frn_div #(.DIV_W(ETA_W), .QUO_W(FRAC_W), .SIDE_W(SNL_W)) u_div_snell (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v6_ff),
      .in_num    (num6_ff),
      .in_den    (snl6_ff.media.eta_t),
      .in_side   (snl6_ff),
      .out_valid (v7d),
      .out_quo   (sin_t),
      .out_side  (snl7_raw)
   );

   // Stage 7: radicand for cos_t
   logic [2*FRAC_W-1:0] st_sq;
   logic [RAD_W-1:0]    rad7_ff;
   frn_snell_type       snl7_ff;
   logic                v7_ff;

   assign st_sq = sin_t * sin_t;

   always_ff @(posedge clock) begin
      if (adv) begin
         rad7_ff <= RAD_ONE - {2'b00, st_sq};
         snl7_ff <= frn_snell_type'(snl7_raw);
      end
   end

   // cos_t
   logic              v8;
   logic [ROOT_W-1:0] cos_t;
   logic [SNL_W-1:0]  snl8_raw;
   frn_snell_type     snl8;

   frn_sqrt #(.ROOT_BITS(ROOT_W), .SIDE_W(SNL_W)) u_sqrt_cos (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v7_ff),
      .in_rad    (rad7_ff),
      .in_side   (snl7_ff),
      .out_valid (v8),
      .out_root  (cos_t),
      .out_side  (snl8_raw)
   );

   assign snl8 = frn_snell_type'(snl8_raw);

   // Stage 9: the four Q.40 products
   logic [PROD_W-1:0] apa_ff, bpa_ff, ape_ff, bpe_ff;
   logic              tir9_ff, v9_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         apa_ff  <= snl8.media.eta_t * snl8.media.cos_i;
         bpa_ff  <= snl8.media.eta_i * cos_t;
         ape_ff  <= snl8.media.eta_i * snl8.media.cos_i;
         bpe_ff  <= snl8.media.eta_t * cos_t;
         tir9_ff <= snl8.tir;
      end
   end

   // Stage 10: difference and sum of each pair
   logic [DEN_W-1:0]        den_pa_in, den_pe_in, den_pa_ff, den_pe_ff;
   logic [PROD_W-1:0]       dif_pa, dif_pe;
   logic [DEN_W+COEF_W-1:0] num_pa_ff, num_pe_ff;
   logic                    tir10_ff, zero10_ff, v10_ff;

   assign den_pa_in = {1'b0, apa_ff} + {1'b0, bpa_ff};
   assign den_pe_in = {1'b0, ape_ff} + {1'b0, bpe_ff};
   assign dif_pa    = (apa_ff >= bpa_ff) ? (apa_ff - bpa_ff) : (bpa_ff - apa_ff);
   assign dif_pe    = (ape_ff >= bpe_ff) ? (ape_ff - bpe_ff) : (bpe_ff - ape_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         den_pa_ff <= den_pa_in;
         den_pe_ff <= den_pe_in;
         num_pa_ff <= {2'b00, dif_pa, {COEF_SH{1'b0}}};
         num_pe_ff <= {2'b00, dif_pe, {COEF_SH{1'b0}}};
         tir10_ff  <= tir9_ff;
         zero10_ff <= (den_pa_in == '0) || (den_pe_in == '0);
      end
   end

   // Both Fresnel coefficients
   logic              v_pa, v_pe, zero11, tir11;
   logic [COEF_W-1:0] r_pa, r_pe;

   frn_div #(.DIV_W(DEN_W), .QUO_W(COEF_W), .SIDE_W(1)) u_div_para (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v10_ff),
      .in_num    (num_pa_ff),
      .in_den    (den_pa_ff),
      .in_side   (zero10_ff),
      .out_valid (v_pa),
      .out_quo   (r_pa),
      .out_side  (zero11)
   );

   frn_div #(.DIV_W(DEN_W), .QUO_W(COEF_W), .SIDE_W(1)) u_div_perp (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v10_ff),
      .in_num    (num_pe_ff),
      .in_den    (den_pe_ff),
      .in_side   (tir10_ff),
      .out_valid (v_pe),
      .out_quo   (r_pe),
      .out_side  (tir11)
   );

   // Stage 12: squares
   logic [SQR_W-1:0] sq_pa_ff, sq_pe_ff;
   logic             tir12_ff, zero12_ff, v12_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_pa_ff  <= r_pa * r_pa;
         sq_pe_ff  <= r_pe * r_pe;
         tir12_ff  <= tir11;
         zero12_ff <= zero11;
      end
   end

   // Stage 13: mean, round, saturate into the output register
   logic [SQR_W:0]      sum;
   logic [SQR_W-22:0]   mean;
   logic [REFL_W-1:0]   refl_in, refl_ff;
   logic                tir_ff, v13_ff;

   assign sum  = {1'b0, sq_pa_ff} + {1'b0, sq_pe_ff} + (SQR_W+1)'(2097152);
   assign mean = sum[SQR_W:22];

   always_comb begin
      if (tir12_ff || zero12_ff || (mean > {1'b0, REFL_ONE})) begin
         refl_in = REFL_ONE;
      end else begin
         refl_in = mean[REFL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         refl_ff <= refl_in;
         tir_ff  <= tir12_ff;
      end
   end

   // Valid bits of the local stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v12_ff <= 1'b0;
         v13_ff <= 1'b0;
      end else if (adv) begin
         v1_ff  <= req_tvalid;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v5_ff  <= v4;
         v6_ff  <= v5_ff;
         v7_ff  <= v7d;
         v9_ff  <= v8;
         v10_ff <= v9_ff;
         v12_ff <= v_pa && v_pe;
         v13_ff <= v12_ff;
      end
   end

   assign rsp_tvalid   = v13_ff;
   assign rsp_tdata    = refl_ff;
   assign rsp_tuser[0] = tir_ff;

   // Total internal reflection always reports full reflectance
   a_tir_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == REFL_ONE)
      else $error("total internal reflection without full reflectance");

   // Reflectance never exceeds one
   a_refl_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= REFL_ONE)
      else $error("reflectance above 1.0");

   // An empty output register never blocks input
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // Both coefficient dividers stay in step
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      v_pa == v_pe)
      else $error("coefficient dividers out of step");

endmodule
`default_nettype wire

>>> test/testbench.sv
`default_nettype none
module testbench;
   import frn_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM  = 1200;
   localparam int LATENCY   = 115;
   localparam int MAX_CYCLES = 400000;

   typedef struct packed {
      logic [15:0] reflectance;
      logic        total_internal;
   } fresnel_result_type;

   // Scoreboard: reflectance predictor plus queue of pending results
   class reflectance_board;
      fresnel_result_type pending[$];
      int unsigned        errors;

      static function automatic logic [63:0] root64(logic [63:0] v);
         logic [63:0] r;
         logic [63:0] b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      static function automatic fresnel_result_type predict(logic [111:0] d);
         longint dot;
         logic [63:0] ior, eta_i, eta_t, c, sin_i, sin_t, cos_t;
         logic [63:0] a, b, den, num, rpa, rpe, total;
         logic zero_den;
         fresnel_result_type res;
         dot = longint'($signed(d[15:0])) * longint'($signed(d[63:48]))
             + longint'($signed(d[31:16])) * longint'($signed(d[79:64]))
             + longint'($signed(d[47:32])) * longint'($signed(d[95:80]));
         ior = {48'd0, d[111:96]};
         if (ior == 0) ior = 1;
         if (dot > (64'sd1 <<< 28)) dot = 64'sd1 <<< 28;
         if (dot < -(64'sd1 <<< 28)) dot = -(64'sd1 <<< 28);
         // swap media when leaving the material
         if (dot > 0) begin
            eta_i = ior;
            eta_t = 4096;
         end else begin
            eta_i = 4096;
            eta_t = ior;
         end
         c = (dot < 0) ? -dot : dot;
         sin_i = root64((64'd1 << 56) - c * c);
         sin_t = (eta_i * sin_i) / eta_t;
         if (sin_t >= (64'd1 << 28)) begin
            res.reflectance = REFL_ONE;
            res.total_internal = 1'b1;
            return res;
         end
         cos_t = root64((64'd1 << 56) - sin_t * sin_t);
         zero_den = 1'b0;
         a = eta_t * c;
         b = eta_i * cos_t;
         den = a + b;
         num = (a >= b) ? a - b : b - a;
         if (den == 0) zero_den = 1'b1;
         rpa = (den == 0) ? 0 : (num << 18) / den;
         a = eta_i * c;
         b = eta_t * cos_t;
         den = a + b;
         num = (a >= b) ? a - b : b - a;
         if (den == 0) zero_den = 1'b1;
         rpe = (den == 0) ? 0 : (num << 18) / den;
         res.total_internal = 1'b0;
         if (zero_den) begin
            res.reflectance = REFL_ONE;
            return res;
         end
         total = (rpa * rpa + rpe * rpe + (64'd1 << 21)) >> 22;
         if (total > 32768) total = 32768;
         res.reflectance = total[15:0];
         return res;
      endfunction

      function void note_request(logic [111:0] d);
         pending.push_back(predict(d));
      endfunction

      function void check_response(logic [15:0] refl, logic tir);
         fresnel_result_type want;
         if (pending.size() == 0) begin
            $error("unexpected result: reflectance %0d total_internal %0d", refl, tir);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (refl !== want.reflectance) begin
            $error("reflectance: expected %0d, got %0d", want.reflectance, refl);
            errors++;
         end
         if (tir !== want.total_internal) begin
            $error("total_internal: expected %0d, got %0d", want.total_internal, tir);
            errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [111:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [15:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         stimulus_done;
   logic         sink_stall_off;
   int unsigned  cycle_count;

   reflectance_board board;

   fresnel_dielectric_reflectance_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [111:0] pack_item(logic [15:0] ix, logic [15:0] iy,
         logic [15:0] iz, logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
         logic [15:0] eta);
      return {eta, nz, ny, nx, iz, iy, ix};
   endfunction

   // Hold one item on the request channel until its transfer, then idle for gap if nonzero
   task automatic send_item(logic [111:0] d, int unsigned gap);
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      board.note_request(d);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] unit_comp();
      // component of magnitude up to 1.0, sign random
      logic [15:0] v;
      v = 16'($urandom_range(16384));
      return $urandom_range(1) ? -v : v;
   endfunction

   function automatic int unsigned draw_gap(bit quiet);
      if (quiet) return 0;
      return $urandom_range(14);
   endfunction

   // Stimulus
   initial begin
      logic [15:0] ix, iy, iz, nx, ny, nz, eta;
      int unsigned kind;
      bit quiet;
      board = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      stimulus_done = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: normal, 45-degree and grazing incidence, both sides, index extremes, raw extremes
      send_item(pack_item(16'h0000, 16'h0000, -16'sd16384, 0, 0, 16'd16384, 16'd6144), 0);
      send_item(pack_item(16'h0000, 16'h0000, 16'd16384, 0, 0, 16'd16384, 16'd6144), 0);
      send_item(pack_item(16'd16384, 0, 0, 0, 0, 16'd16384, 16'd6144), 0);
      send_item(pack_item(16'd16384, 0, 0, 0, 0, 16'd16384, 16'd4096), 1);
      send_item(pack_item(16'd11585, 0, 16'd11585, 0, 0, 16'd16384, 16'd6144), 0);
      send_item(pack_item(16'd11585, 0, -16'sd11585, 0, 0, 16'd16384, 16'd6144), 2);
      send_item(pack_item(16'd11585, 0, 16'd11585, 0, 0, 16'd16384, 16'd4096), 0);
      send_item(pack_item(0, 0, -16'sd16384, 0, 0, 16'd16384, 16'd0), 0);
      send_item(pack_item(0, 0, 16'd16384, 0, 0, 16'd16384, 16'd0), 0);
      send_item(pack_item(0, 0, -16'sd16384, 0, 0, 16'd16384, 16'd1), 3);
      send_item(pack_item(0, 0, -16'sd16384, 0, 0, 16'd16384, 16'hFFFF), 0);
      send_item(pack_item(0, 0, 16'd16384, 0, 0, 16'd16384, 16'hFFFF), 0);
      send_item(pack_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                          16'h7FFF, 16'd6144), 0);
      send_item(pack_item(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                          16'h7FFF, 16'd6144), 0);
      send_item(pack_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                          16'h8000, 16'h8000), 0);
      send_item(pack_item(0, 0, 0, 0, 0, 0, 16'd6144), 4);
      send_item(pack_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 16'hFFFF), 0);
      send_item(pack_item(16'd15000, 0, 16'd6000, 0, 0, 16'd16384, 16'd2048), 0);

      // hold off until the pipeline has drained
      req_tvalid <= 1'b0;
      wait_drained();

      // random: mostly unit-ish vectors, some raw bit patterns
      for (int i = 0; i < N_RANDOM; i++) begin
         quiet = (i / 150) % 3 == 1;
         kind = $urandom_range(9);
         if (kind < 7) begin
            ix = unit_comp(); iy = unit_comp(); iz = unit_comp();
            nx = unit_comp(); ny = unit_comp(); nz = unit_comp();
            eta = 16'(($urandom_range(2) == 0) ? $urandom()
                                                : $urandom_range(3000, 12288));
         end else begin
            {ix, iy, iz} = 48'({$urandom(), $urandom()});
            {nx, ny, nz} = 48'({$urandom(), $urandom()});
            eta = 16'($urandom());
         end
         send_item(pack_item(ix, iy, iz, nx, ny, nz, eta), draw_gap(quiet));
      end
      req_tvalid <= 1'b0;
      stimulus_done <= 1'b1;
   end

   // Result sink with random stalls
   initial begin
      int unsigned stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         sink_stall_off = ($urandom_range(3) == 0);
         stall = sink_stall_off ? 0 : $urandom_range(14);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Check each result transfer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response(rsp_tdata, rsp_tuser[0]);
   end

   // End of run and timeout
   initial begin
      cycle_count = 0;
      fork
         begin
            wait (stimulus_done === 1'b1);
            wait_drained();
            repeat (LATENCY + 20) @(posedge clock);
         end
         begin
            while (cycle_count < MAX_CYCLES) begin
               @(posedge clock);
               cycle_count++;
            end
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench NOT OK");
            $finish;
         end
      join_any
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("testbench OK");
      end else begin
         if (board.pending.size() != 0)
            $error("%0d expected results never arrived", board.pending.size());
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire
